// ===== sv/pasf_pkg.sv =====
// Shared types and constants for the period average to scaled frequency core.
// Holds the beat structs, register indexes and clamp limits; no dependencies.
package pasf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 28;

  localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_HZ     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAL_IN_LOW   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAL_IN_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAL_OUT_LOW  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAL_OUT_HIGH = 3'd4;

  localparam logic [27:0] TIMER_HZ_RESET     = 28'd125000000;
  localparam logic [23:0] CAL_IN_LOW_RESET   = 24'd20000;
  localparam logic [23:0] CAL_IN_HIGH_RESET  = 24'd25000;
  localparam logic [12:0] CAL_OUT_LOW_RESET  = 13'd100;
  localparam logic [12:0] CAL_OUT_HIGH_RESET = 13'd500;

  localparam logic [20:0] FREQ_MIN_Q8 = 21'd12800;    // 50 Hz
  localparam logic [20:0] FREQ_MAX_Q8 = 21'd1280000;  // 5000 Hz

  typedef struct packed {
    logic [1:0]  channel;
    logic [15:0] period_ticks;
    logic        buffer_end;
  } in_t;

  typedef struct packed {
    logic [1:0]  out_channel;
    logic [20:0] frequency_q8;
  } out_t;

endpackage

// ===== sv/period_average_to_scaled_frequency_core.sv =====
// Per-channel period accumulation with reciprocal frequency and linear calibration.
// Uses pasf_pkg for beat structs, register indexes and clamp limits.
// Beats without buffer_end are taken back to back. For a buffer_end beat the core steps
// through S_MUL1, S_DIV1, S_SUB, S_MUL2A, S_MUL2B, S_DIV2, S_FIN and S_OUT before out_valid
// rises; equal calibration inputs go straight to S_FIN and a zero sum to S_OUT. S_OUT waits
// while an earlier result still waits for out_ready; in_ready stays low until S_IDLE. The
// quotients come from one bit-serial restoring divider that runs twice (frequency, then
// calibration slope), one quotient bit per cycle.
// Synchronous reset restores register defaults and clears all sums and counts.
module period_average_to_scaled_frequency_core #(
  parameter int CHANNELS    = 4,
  parameter int MAX_SAMPLES = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pasf_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pasf_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [pasf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pasf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM1 = 28 + CW + 8;      // timer_hz * count * 256
  localparam int MW   = NUM1 + 13;        // |d| * |dout|
  localparam int IW   = $clog2(MW + 1);
  localparam int RW   = MW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_DIV1, S_SUB, S_MUL2A, S_MUL2B, S_DIV2, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [27:0] timer_hz;
  logic [23:0] cal_in_low, cal_in_high;
  logic [12:0] cal_out_low, cal_out_high;

  logic [23:0]   tick_sum     [CHANNELS];
  logic [CW-1:0] sample_count [CHANNELS];

  logic [23:0]   sum_l;
  logic [CW-1:0] cnt_l;
  logic [1:0]    ch_l;
  logic [MW-1:0] dreg;
  logic [23:0]   rem;
  logic [23:0]   dv;
  logic [IW-1:0] icnt;
  logic [MW-1:0] acc;
  logic [NUM1-1:0] dmag;
  logic            neg;
  logic [20:0]     res;

  logic            accept, ch_ok;
  logic [CHW-1:0]  sel;
  logic [23:0]     cur_sum, sum_upd;
  logic [CW-1:0]   cur_cnt, cnt_upd;
  logic [24:0]     sum_add;
  logic            keep;
  logic signed [24:0] din;
  logic [23:0]     din_mag;
  logic signed [13:0] dout;
  logic [12:0]     dout_mag;
  logic [NUM1-1:0] num1;
  logic signed [NUM1:0] d_val;
  logic [24:0]     rs;
  logic            ge;
  logic [23:0]     rem_next;
  logic [MW-1:0]   dreg_next;
  logic [MW-1:0]   hi_part;
  logic signed [RW-1:0] s_val, r_val;
  logic [20:0]     lo_q8, res_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ch_ok   = {3'b000, in_data.channel} < 5'(CHANNELS);
    sel     = CHW'(in_data.channel);
    cur_sum = tick_sum[sel];
    cur_cnt = sample_count[sel];
    keep    = cur_cnt < CW'(MAX_SAMPLES);
    sum_add = {1'b0, cur_sum} + {9'd0, in_data.period_ticks};
    if (keep) begin
      sum_upd = sum_add[24] ? 24'hFFFFFF : sum_add[23:0];
      cnt_upd = cur_cnt + CW'(1);
    end else begin
      sum_upd = cur_sum;
      cnt_upd = cur_cnt;
    end

    din      = $signed({1'b0, cal_in_high}) - $signed({1'b0, cal_in_low});
    din_mag  = din[24] ? 24'(-din) : din[23:0];
    dout     = $signed({1'b0, cal_out_high}) - $signed({1'b0, cal_out_low});
    dout_mag = dout[13] ? 13'(-dout) : dout[12:0];

    num1  = {(28 + CW)'(timer_hz) * (28 + CW)'(cnt_l), 8'd0};
    d_val = $signed({1'b0, dreg[NUM1-1:0]})
          - $signed((NUM1 + 1)'({cal_in_low, 8'd0}));

    rs        = {rem, dreg[MW-1]};
    ge        = rs >= {1'b0, dv};
    rem_next  = ge ? 24'(rs - {1'b0, dv}) : rs[23:0];
    dreg_next = {dreg[MW-2:0], ge};

    hi_part = MW'(dmag[NUM1-1:32] * (NUM1 - 19)'(dout_mag)) << 32;

    lo_q8 = {cal_out_low, 8'd0};
    s_val = neg ? -$signed(RW'(dreg)) : $signed(RW'(dreg));
    r_val = s_val + $signed(RW'(lo_q8));
    if (r_val < $signed(RW'(pasf_pkg::FREQ_MIN_Q8))) begin
      res_next = pasf_pkg::FREQ_MIN_Q8;
    end else if (r_val > $signed(RW'(pasf_pkg::FREQ_MAX_Q8))) begin
      res_next = pasf_pkg::FREQ_MAX_Q8;
    end else begin
      res_next = r_val[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      timer_hz     <= pasf_pkg::TIMER_HZ_RESET;
      cal_in_low   <= pasf_pkg::CAL_IN_LOW_RESET;
      cal_in_high  <= pasf_pkg::CAL_IN_HIGH_RESET;
      cal_out_low  <= pasf_pkg::CAL_OUT_LOW_RESET;
      cal_out_high <= pasf_pkg::CAL_OUT_HIGH_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        tick_sum[i]     <= '0;
        sample_count[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pasf_pkg::CFG_TIMER_HZ:     timer_hz     <= cfg_data;
          pasf_pkg::CFG_CAL_IN_LOW:   cal_in_low   <= cfg_data[23:0];
          pasf_pkg::CFG_CAL_IN_HIGH:  cal_in_high  <= cfg_data[23:0];
          pasf_pkg::CFG_CAL_OUT_LOW:  cal_out_low  <= cfg_data[12:0];
          pasf_pkg::CFG_CAL_OUT_HIGH: cal_out_high <= cfg_data[12:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && ch_ok) begin
            if (in_data.buffer_end) begin
              tick_sum[sel]     <= '0;
              sample_count[sel] <= '0;
              sum_l <= sum_upd;
              cnt_l <= cnt_upd;
              ch_l  <= in_data.channel;
              if (sum_upd == 24'd0) begin
                res   <= pasf_pkg::FREQ_MAX_Q8;
                state <= S_OUT;
              end else if (din == 25'sd0) begin
                dreg  <= '0;
                neg   <= 1'b0;
                state <= S_FIN;
              end else begin
                state <= S_MUL1;
              end
            end else begin
              tick_sum[sel]     <= sum_upd;
              sample_count[sel] <= cnt_upd;
            end
          end
        end
        S_MUL1: begin
          dreg  <= {num1, {(MW - NUM1){1'b0}}};
          rem   <= '0;
          dv    <= sum_l;
          icnt  <= IW'(NUM1);
          state <= S_DIV1;
        end
        S_DIV1: begin
          dreg <= dreg_next;
          rem  <= rem_next;
          icnt <= icnt - IW'(1);
          if (icnt == IW'(1)) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          dmag  <= d_val[NUM1] ? NUM1'(-d_val) : d_val[NUM1-1:0];
          neg   <= d_val[NUM1] ^ dout[13] ^ din[24];
          state <= S_MUL2A;
        end
        S_MUL2A: begin
          acc   <= MW'(dmag[31:0] * 45'(dout_mag));
          state <= S_MUL2B;
        end
        S_MUL2B: begin
          dreg  <= acc + hi_part;
          rem   <= '0;
          dv    <= din_mag;
          icnt  <= IW'(MW);
          state <= S_DIV2;
        end
        S_DIV2: begin
          dreg <= dreg_next;
          rem  <= rem_next;
          icnt <= icnt - IW'(1);
          if (icnt == IW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res   <= res_next;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.out_channel  <= ch_l;
            out_data.frequency_q8 <= res;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_period_average_to_scaled_frequency_core.sv =====
`timescale 1ns / 100ps
// Testbench for period_average_to_scaled_frequency_core: sends period beats and register
// writes, predicts every calibrated frequency beat and compares it field by field.
// Depends on pasf_pkg and the core RTL only.
module tb_period_average_to_scaled_frequency_core;

  localparam int     CHANNELS    = 4;
  localparam int     MAX_SAMPLES = 256;
  localparam int     SETTLE      = 150;
  localparam longint CYCLE_LIMIT = 1500000;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  pasf_pkg::in_t                    in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  pasf_pkg::out_t                   out_data;
  logic                             cfg_we    = 1'b0;
  logic [pasf_pkg::CFG_INDEX_W-1:0] cfg_index = pasf_pkg::CFG_TIMER_HZ;
  logic [pasf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // predictor copy of the registers and per-channel accumulators
  logic [27:0] hz_tick;
  logic [23:0] in_lo, in_hi;
  logic [12:0] out_lo, out_hi;
  logic [23:0] acc_ticks   [CHANNELS];
  logic [8:0]  acc_samples [CHANNELS];

  pasf_pkg::out_t freq_expected [$];
  int     errors     = 0;
  longint cycles     = 0;
  int     gap_max    = 0;
  int     stall_max  = 0;
  int     ready_wait = 0;

  period_average_to_scaled_frequency_core #(
    .CHANNELS    (CHANNELS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [20:0] scaled_freq_q8(logic [23:0] sum, logic [8:0] count);
    longint unsigned num, den, fq;
    longint          lo_in, hi_in, lo_out, hi_out, v, lo_q, hi_q;
    lo_in  = in_lo;
    hi_in  = in_hi;
    lo_out = out_lo;
    hi_out = out_hi;
    lo_q   = pasf_pkg::FREQ_MIN_Q8;
    hi_q   = pasf_pkg::FREQ_MAX_Q8;
    if (sum == 0) return pasf_pkg::FREQ_MAX_Q8;
    if (hi_in == lo_in) begin
      v = lo_out * 256;
    end else begin
      num = hz_tick;
      num = num * count * 256;
      den = sum;
      fq  = num / den;
      v = ($signed(fq) - lo_in * 256) * (hi_out - lo_out) / (hi_in - lo_in) + lo_out * 256;
    end
    if (v < lo_q) v = lo_q;
    if (v > hi_q) v = hi_q;
    return v[20:0];
  endfunction

  function automatic void accept_period(pasf_pkg::in_t b);
    logic [24:0]    total;
    pasf_pkg::out_t r;
    int             ch;
    ch = b.channel;
    if (ch >= CHANNELS) return;
    if (acc_samples[ch] < MAX_SAMPLES) begin
      total = acc_ticks[ch] + b.period_ticks;
      acc_ticks[ch]   = total[24] ? 24'hFFFFFF : total[23:0];
      acc_samples[ch] = acc_samples[ch] + 9'd1;
    end
    if (b.buffer_end) begin
      r.out_channel  = b.channel;
      r.frequency_q8 = scaled_freq_q8(acc_ticks[ch], acc_samples[ch]);
      freq_expected.push_back(r);
      acc_ticks[ch]   = '0;
      acc_samples[ch] = '0;
    end
  endfunction

  // result side: compare each beat with the oldest prediction, then a random stall
  always @(posedge clk) begin : rx
    int             w;
    pasf_pkg::out_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      ready_wait <= 0;
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, stall_max);
      ready_wait <= w;
      out_ready  <= (w == 0);
      if (freq_expected.size() == 0) begin
        $display("%0t: unexpected beat, channel %0d freq_q8 %0d", $time,
                 out_data.out_channel, out_data.frequency_q8);
        errors = errors + 1;
      end else begin
        want = freq_expected.pop_front();
        if (out_data.out_channel !== want.out_channel) begin
          $display("%0t: out_channel expected %0d actual %0d", $time,
                   want.out_channel, out_data.out_channel);
          errors = errors + 1;
        end
        if (out_data.frequency_q8 !== want.frequency_q8) begin
          $display("%0t: frequency_q8 expected %0d actual %0d", $time,
                   want.frequency_q8, out_data.frequency_q8);
          errors = errors + 1;
        end
      end
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      out_ready  <= (ready_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic pasf_pkg::in_t make_period(logic [1:0] ch, logic [15:0] ticks,
                                                logic last);
    pasf_pkg::in_t b;
    b.channel      = ch;
    b.period_ticks = ticks;
    b.buffer_end   = last;
    return b;
  endfunction

  task automatic send_period(pasf_pkg::in_t b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_period(b);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (freq_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic [27:0] hz, logic [27:0] il, logic [27:0] ih,
                            logic [27:0] ol, logic [27:0] oh);
    logic [pasf_pkg::CFG_INDEX_W-1:0] idx [5];
    logic [27:0]                      val [5];
    idx = '{pasf_pkg::CFG_TIMER_HZ, pasf_pkg::CFG_CAL_IN_LOW, pasf_pkg::CFG_CAL_IN_HIGH,
            pasf_pkg::CFG_CAL_OUT_LOW, pasf_pkg::CFG_CAL_OUT_HIGH};
    val = '{hz, il, ih, ol, oh};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    hz_tick = hz;
    in_lo   = il[23:0];
    in_hi   = ih[23:0];
    out_lo  = ol[12:0];
    out_hi  = oh[12:0];
  endtask

  // mostly periods near center, some full-scale noise and zero/max ticks
  task automatic run_burst(int n, int center, int spread);
    int          roll, t;
    logic [15:0] ticks;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        t = center - spread + $urandom_range(0, 2 * spread);
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        ticks = t[15:0];
      end else if (roll == 8) begin
        ticks = 16'($urandom);
      end else begin
        ticks = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      send_period(make_period(2'($urandom), ticks, $urandom_range(0, 5) == 0));
    end
  endtask

  task automatic calibration_phase(logic [27:0] hz, logic [27:0] il, logic [27:0] ih,
                                   logic [27:0] ol, logic [27:0] oh, int center, int n);
    set_config(hz, il, ih, ol, oh);
    run_burst(n, center, center / 8 + 1);
    wait_idle();
  endtask

  task automatic test_directed();
    gap_max   = 0;
    stall_max = 0;
    send_period(make_period(2'd0, 16'd5000, 1'b0));
    send_period(make_period(2'd0, 16'd5000, 1'b0));
    send_period(make_period(2'd0, 16'd5000, 1'b1));
    send_period(make_period(2'd1, 16'd6250, 1'b1));
    send_period(make_period(2'd2, 16'd0, 1'b1));
    send_period(make_period(2'd3, 16'hFFFF, 1'b1));
    send_period(make_period(2'd0, 16'd1, 1'b1));
    send_period(make_period(2'd1, 16'd0, 1'b0));
    send_period(make_period(2'd1, 16'd0, 1'b0));
    send_period(make_period(2'd1, 16'd0, 1'b1));
    send_period(make_period(2'd2, 16'd5500, 1'b0));
    send_period(make_period(2'd3, 16'd5600, 1'b0));
    send_period(make_period(2'd2, 16'd5700, 1'b1));
    send_period(make_period(2'd3, 16'd5800, 1'b1));
    send_period(make_period(2'd0, 16'hFFFF, 1'b0));
    send_period(make_period(2'd0, 16'h0000, 1'b0));
    send_period(make_period(2'd0, 16'hAAAA, 1'b0));
    send_period(make_period(2'd0, 16'h5555, 1'b1));
    send_period(make_period(2'd3, 16'd5555, 1'b1));
    wait_idle();
  endtask

  task automatic test_buffer_overflow();
    gap_max   = 1;
    stall_max = 5;
    for (int i = 0; i < 270; i++)
      send_period(make_period(2'd2, 16'($urandom_range(4000, 8000)), i == 269));
    // the end beat's sample lands past the limit and is not counted, but it still ends the buffer
    for (int i = 0; i < 257; i++)
      send_period(make_period(2'd1, 16'($urandom_range(5000, 6250)), i == 256));
    wait_idle();
  endtask

  task automatic test_calibration_extremes();
    gap_max   = 5;
    stall_max = 5;
    calibration_phase(28'd125000000, 28'd20000, 28'd20000, 28'd300, 28'd4000, 5500, 16);
    calibration_phase(28'd125000000, 28'd30000, 28'd30000, 28'd8191, 28'd0, 5500, 16);
    calibration_phase(28'd125000000, 28'd20000, 28'd25000, 28'd5000, 28'd0, 5500, 16);
    calibration_phase(28'd0, 28'd20000, 28'd25000, 28'd100, 28'd500, 5500, 16);
    calibration_phase(28'hFFFFFFF, 28'd1, 28'hFFFFFF, 28'd0, 28'd5000, 40, 16);
    calibration_phase(28'd1, 28'd1, 28'd2, 28'd5000, 28'd0, 2, 16);
    calibration_phase(28'd200000000, 28'hFFFFFFF, 28'hA000001, 28'hFFFFFFF, 28'h1000,
                      300, 16);
    calibration_phase(28'd125000000, 28'd10000000, 28'd1, 28'd0, 28'd0, 12, 16);
  endtask

  task automatic test_random();
    longint hz, meas, lo, hi;
    int     center;
    for (int phase = 0; phase < 11; phase++) begin
      gap_max   = (phase % 3 == 0) ? 0 : 5;
      stall_max = (phase % 4 == 1) ? 0 : 5;
      center = $urandom_range(20, 60000);
      hz     = $urandom_range(1000000, 200000000);
      meas   = hz / center;
      lo     = meas * $urandom_range(85, 99) / 100;
      hi     = meas * $urandom_range(101, 115) / 100;
      if (lo < 1) lo = 1;
      if (hi < 1) hi = 1;
      if (lo > 24'hFFFFFF) lo = 24'hFFFFFF;
      if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
      calibration_phase(28'(hz), 28'(lo), 28'(hi), 28'($urandom_range(0, 5000)),
                        28'($urandom_range(0, 5000)), center, 110);
    end
  endtask

  initial begin
    hz_tick = pasf_pkg::TIMER_HZ_RESET;
    in_lo   = pasf_pkg::CAL_IN_LOW_RESET;
    in_hi   = pasf_pkg::CAL_IN_HIGH_RESET;
    out_lo  = pasf_pkg::CAL_OUT_LOW_RESET;
    out_hi  = pasf_pkg::CAL_OUT_HIGH_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      acc_ticks[i]   = '0;
      acc_samples[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_buffer_overflow();
    test_calibration_extremes();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pasf_pkg.sv
sv/period_average_to_scaled_frequency_core.sv
sim/tb_period_average_to_scaled_frequency_core.sv
